@@ hdl/rtnps_pkg.sv @@
// Shared types and constants for the R-tree nearest point search block.
// No dependencies; imported by hdl/rtree_nearest_point_search.sv.
package rtnps_pkg;

  // Table sizes (NODE_DEPTH and BOUND_ENTRIES must be powers of two)
  localparam int NODE_DEPTH    = 8192;
  localparam int BOUND_ENTRIES = 256;
  localparam int MAX_LEVELS    = 8;
  localparam int DIMENSIONS    = 6;

  localparam int NA_W  = $clog2(NODE_DEPTH);
  localparam int BA_W  = $clog2(BOUND_ENTRIES);
  localparam int STK_W = $clog2(MAX_LEVELS);
  localparam int LVL_W = $clog2(MAX_LEVELS + 1);

  localparam int IN_DATA_W  = 352;
  localparam int OUT_DATA_W = 24;

  // Distance sequencer: last cycle, when the sum is complete
  localparam logic [3:0] DIST_LAST = 4'(DIMENSIONS + 3);

  // Input item kinds
  localparam logic [1:0] MODE_NODE   = 2'd0;
  localparam logic [1:0] MODE_BOUND  = 2'd1;
  localparam logic [1:0] MODE_STRIDE = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CHILD_COUNT = 1'b0;
  localparam logic CFG_NODE_TOTAL  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALL,
    S_LVL,
    S_INNER,
    S_CHILD,
    S_DIST,
    S_NEXT,
    S_RET,
    S_FIN,
    S_EMIT
  } state_t;

  // One suspended level of the walk
  typedef struct packed {
    logic [15:0]      inner;
    logic [15:0]      step;
    logic [15:0]      leaf;
    logic [63:0]      ds;
    logic [LVL_W-1:0] depth;
    logic [4:0]       cnt;
    logic [63:0]      di;
  } frame_t;

endpackage

@@ hdl/rtree_nearest_point_search.sv @@
// Top level of the R-tree nearest point search: tables, walk sequencer and
// box distance unit. Depends on hdl/rtnps_pkg.sv.
//
// Usage:
//   in_* carries load and query items; in_tuser holds the mode. Node, bound
//   and stride loads are written in the cycle they are accepted and give no
//   result. A query returns one item on out_*: the nearest leaf index and its
//   biome id.
//   cfg_* writes child_count (index 0) and node_total (index 1); always ready.
// Timing:
//   A query's duration grows with each child box examined, each level
//   entered and each returned candidate that needs its own box distance.
//   The sequential box distance unit (node read, six bound reads, one
//   32x32 multiply per dimension) sets this duration.
//   in_tready is high whenever the walk is idle, also while a result waits.
// Reset: control state clears; child_count returns to 6, node_total to 1.
//   Table contents are not cleared and must be loaded before a query.
// Stall: a result waits in the output register until taken; a finished
//   walk holds in its final state while the earlier result is still pending.
module rtree_nearest_point_search
  import rtnps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // index[12:0], node_word[76:13], bound_min[108:77], bound_max[140:109],
  // level_stride[156:141], temperature[188:157], humidity[220:189],
  // continentalness[252:221], erosion[284:253], depth_value[316:285],
  // weirdness[348:317], zero pad[351:349]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // leaf_index[12:0], biome_id[20:13], zero pad[23:21]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [13:0]           cfg_data
);

  localparam logic [16:0] ND17 = 17'(NODE_DEPTH);

  // Field extraction
  logic [12:0]        f_index;
  logic [63:0]        f_node_word;
  logic [31:0]        f_bound_min;
  logic [31:0]        f_bound_max;
  logic [15:0]        f_stride;
  logic signed [31:0] f_pt [DIMENSIONS];

  assign f_index     = in_tdata[12:0];
  assign f_node_word = in_tdata[76:13];
  assign f_bound_min = in_tdata[108:77];
  assign f_bound_max = in_tdata[140:109];
  assign f_stride    = in_tdata[156:141];
  assign f_pt[0]     = in_tdata[188:157];
  assign f_pt[1]     = in_tdata[220:189];
  assign f_pt[2]     = in_tdata[252:221];
  assign f_pt[3]     = in_tdata[284:253];
  assign f_pt[4]     = in_tdata[316:285];
  assign f_pt[5]     = in_tdata[348:317];

  // Registers
  state_t             state_r, state_nxt;
  logic [4:0]         child_count_r;
  logic [13:0]        node_total_r;
  logic signed [31:0] pt_r [DIMENSIONS];
  logic [15:0]        inner_r, inner_nxt;
  logic [15:0]        step_r, step_nxt;
  logic [15:0]        leaf_r, leaf_nxt;
  logic [63:0]        ds_r, ds_nxt;
  logic [LVL_W-1:0]   depth_r, depth_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [15:0]        ret_r, ret_nxt;
  logic               dsel_r, dsel_nxt;
  logic [3:0]         dcnt_r, dcnt_nxt;
  logic [31:0]        d_r;
  logic [63:0]        prod_r;
  logic [63:0]        acc_r, acc_nxt;
  logic [12:0]        res_leaf_r;
  logic [7:0]         res_biome_r;
  logic               out_valid_r;
  logic [12:0]        out_leaf_r;
  logic [7:0]         out_biome_r;

  // Memories and walk stack
  logic [63:0]        node_mem [NODE_DEPTH];
  logic [63:0]        bound_mem [BOUND_ENTRIES];
  logic [15:0]        stride_r [MAX_LEVELS];
  frame_t             stk_r [MAX_LEVELS];
  logic [63:0]        node_q;
  logic [63:0]        bound_q;

  logic               node_re;
  logic [15:0]        node_raddr;
  logic               push;
  frame_t             push_f;
  frame_t             pop_f;

  // Handshakes
  logic in_acc;
  logic out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Effective node count
  logic [16:0] len;
  always_comb begin
    if (node_total_r == 14'd0) begin
      len = 17'd1;
    end else if ({3'b000, node_total_r} > ND17) begin
      len = ND17;
    end else begin
      len = {3'b000, node_total_r};
    end
  end

  // Walk conditions
  logic [15:0] stride_cur;
  logic [16:0] lvl_sum;
  logic [LVL_W-1:0] depth_inc;
  logic        lvl_more;
  logic        dist_done;
  logic        take;
  logic        child_end;
  logic [15:0] next_inner;
  logic        next_end;
  logic        pop_same;
  logic [STK_W-1:0] pop_idx;

  assign stride_cur = (depth_r < LVL_W'(MAX_LEVELS)) ? stride_r[depth_r[STK_W-1:0]] : 16'd0;
  assign lvl_sum    = {1'b0, inner_r} + {1'b0, stride_cur};
  assign depth_inc  = depth_r + LVL_W'(1);
  assign lvl_more   = (lvl_sum >= len) && (depth_inc < LVL_W'(MAX_LEVELS));
  assign dist_done  = (dcnt_r == DIST_LAST);
  assign take       = (acc_r < ds_r);
  assign child_end  = (cnt_r >= child_count_r);
  assign next_inner = inner_r + step_r;
  assign next_end   = ({1'b0, next_inner} >= len);
  assign pop_idx    = STK_W'(lvl_r - LVL_W'(1));
  assign pop_f      = stk_r[pop_idx];
  assign pop_same   = (ret_r == pop_f.inner);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == MODE_QUERY) state_nxt = S_CALL;
      end
      S_CALL:  state_nxt = (stride_cur == 16'd0) ? S_RET : S_LVL;
      S_LVL:   state_nxt = lvl_more ? S_LVL : S_INNER;
      S_INNER: state_nxt = S_CHILD;
      S_CHILD: state_nxt = child_end ? S_RET : S_DIST;
      S_DIST: begin
        if (dist_done) begin
          if (dsel_r) state_nxt = S_NEXT;
          else state_nxt = take ? S_CALL : S_NEXT;
        end
      end
      S_NEXT:  state_nxt = next_end ? S_RET : S_CHILD;
      S_RET: begin
        if (lvl_r == '0) state_nxt = S_FIN;
        else state_nxt = pop_same ? S_NEXT : S_DIST;
      end
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Walk datapath
  always_comb begin
    inner_nxt  = inner_r;
    step_nxt   = step_r;
    leaf_nxt   = leaf_r;
    ds_nxt     = ds_r;
    depth_nxt  = depth_r;
    lvl_nxt    = lvl_r;
    cnt_nxt    = cnt_r;
    ret_nxt    = ret_r;
    dsel_nxt   = dsel_r;
    dcnt_nxt   = dcnt_r;
    acc_nxt    = acc_r;
    node_re    = 1'b0;
    node_raddr = inner_r;
    push       = 1'b0;
    push_f     = '{inner: inner_r, step: step_r, leaf: leaf_r, ds: ds_r,
                   depth: depth_r, cnt: cnt_r, di: acc_r};
    case (state_r)
      S_IDLE: begin
        inner_nxt = 16'd0;
        leaf_nxt  = 16'd0;
        ds_nxt    = '1;
        depth_nxt = '0;
        lvl_nxt   = '0;
      end
      S_CALL: begin
        ret_nxt = inner_r;
      end
      S_LVL: begin
        step_nxt  = stride_cur;
        depth_nxt = depth_inc;
        if (!lvl_more) node_re = 1'b1;
      end
      S_INNER: begin
        inner_nxt = node_q[63:48];
        cnt_nxt   = 5'd0;
      end
      S_CHILD: begin
        ret_nxt = leaf_r;
        if (!child_end) begin
          node_re  = 1'b1;
          dsel_nxt = 1'b0;
          dcnt_nxt = 4'd0;
          acc_nxt  = 64'd0;
        end
      end
      S_DIST: begin
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r >= 4'd3 && dcnt_r < DIST_LAST) acc_nxt = acc_r + prod_r;
        if (dist_done) begin
          if (dsel_r) begin
            if (take) begin
              ds_nxt   = acc_r;
              leaf_nxt = ret_r;
            end
          end else if (take) begin
            push    = 1'b1;
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      S_NEXT: begin
        inner_nxt = next_inner;
        ret_nxt   = leaf_r;
        if (!next_end) cnt_nxt = cnt_r + 5'd1;
      end
      S_RET: begin
        node_raddr = ret_r;
        if (lvl_r == '0) begin
          node_re = 1'b1;
        end else begin
          // Restore the suspended level and weigh the returned candidate
          inner_nxt = pop_f.inner;
          step_nxt  = pop_f.step;
          depth_nxt = pop_f.depth;
          cnt_nxt   = pop_f.cnt;
          lvl_nxt   = lvl_r - LVL_W'(1);
          leaf_nxt  = pop_f.leaf;
          ds_nxt    = pop_f.ds;
          if (pop_same) begin
            if (pop_f.di < pop_f.ds) begin
              ds_nxt   = pop_f.di;
              leaf_nxt = ret_r;
            end
          end else begin
            node_re  = 1'b1;
            dsel_nxt = 1'b1;
            dcnt_nxt = 4'd0;
            acc_nxt  = 64'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Box distance stages: bound read, excess, square
  logic [2:0]         bsel;
  logic [2:0]         dsel_k;
  logic signed [32:0] above;
  logic signed [32:0] below;
  logic [31:0]        d_nxt;
  logic signed [31:0] b_lo;
  logic signed [31:0] b_hi;

  assign bsel   = dcnt_r[2:0];
  assign dsel_k = 3'(dcnt_r - 4'd1);
  assign b_lo   = bound_q[31:0];
  assign b_hi   = bound_q[63:32];
  assign above  = {pt_r[dsel_k][31], pt_r[dsel_k]} - {b_hi[31], b_hi};
  assign below  = {b_lo[31], b_lo} - {pt_r[dsel_k][31], pt_r[dsel_k]};

  always_comb begin
    if (!above[32] && above != 33'sd0) begin
      d_nxt = above[31:0];
    end else if (!below[32] && below != 33'sd0) begin
      d_nxt = below[31:0];
    end else begin
      d_nxt = 32'd0;
    end
  end

  // Node memory: write on load, read for the walk
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_NODE && {4'b0000, f_index} < ND17) begin
      node_mem[f_index[NA_W-1:0]] <= f_node_word;
    end
    if (node_re) node_q <= node_mem[node_raddr[NA_W-1:0]];
  end

  // Bound memory: one pair per entry, read once per dimension
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_BOUND && f_index < 13'(BOUND_ENTRIES)) begin
      bound_mem[f_index[BA_W-1:0]] <= {f_bound_max, f_bound_min};
    end
    if (state_r == S_DIST && dcnt_r < 4'(DIMENSIONS)) begin
      bound_q <= bound_mem[node_q[8*bsel +: BA_W]];
    end
  end

  // Stride table, target point, stack and arithmetic stages
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_STRIDE && f_index < 13'(MAX_LEVELS)) begin
      stride_r[f_index[STK_W-1:0]] <= f_stride;
    end
    if (in_acc && in_tuser == MODE_QUERY) begin
      for (int k = 0; k < DIMENSIONS; k++) pt_r[k] <= f_pt[k];
    end
    if (push) stk_r[lvl_r[STK_W-1:0]] <= push_f;
    d_r    <= d_nxt;
    prod_r <= {32'd0, d_r} * {32'd0, d_r};
    if (state_r == S_FIN) begin
      res_leaf_r  <= ret_r[12:0];
      res_biome_r <= node_q[55:48];
    end
    if (state_r == S_EMIT && out_free) begin
      out_leaf_r  <= res_leaf_r;
      out_biome_r <= res_biome_r;
    end
    inner_r <= inner_nxt;
    step_r  <= step_nxt;
    leaf_r  <= leaf_nxt;
    ds_r    <= ds_nxt;
    cnt_r   <= cnt_nxt;
    ret_r   <= ret_nxt;
    acc_r   <= acc_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      child_count_r <= 5'd6;
      node_total_r  <= 14'd1;
      depth_r       <= '0;
      lvl_r         <= '0;
      dsel_r        <= 1'b0;
      dcnt_r        <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      lvl_r   <= lvl_nxt;
      dsel_r  <= dsel_nxt;
      dcnt_r  <= dcnt_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_CHILD_COUNT) child_count_r <= cfg_data[4:0];
        else node_total_r <= cfg_data;
      end
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_biome_r, out_leaf_r};

  // Checks
  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> lvl_r < LVL_W'(MAX_LEVELS))
    else $error("walk stack overflow");
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIST |-> dcnt_r <= DIST_LAST)
    else $error("distance sequencer overran");
  a_top_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RET && lvl_r == '0) |=> state_r == S_FIN)
    else $error("top level return lost");
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && state_r != S_EMIT) |=> !out_valid_r)
    else $error("result delivered twice");

endmodule
